>>> rtl/skvt_pkg.sv
// shared types and codes of the sorted key/value table
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP = 3'd0,
      KIND_SET    = 3'd1,
      KIND_INSERT = 3'd2,
      KIND_ERASE  = 3'd3,
      KIND_PROBE  = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LSCAN,
      ST_BREAD,
      ST_BCMP,
      ST_DISPATCH,
      ST_SHIFT,
      ST_PLACE,
      ST_PROBE_RD,
      ST_PROBE_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       found;
      status_type status;
   } rsp_meta_type;

endpackage

`default_nettype wire

>>> rtl/skvt_ifs.sv
// channel interfaces of the sorted key/value table
`timescale 1ns / 1ps
`default_nettype none

interface skvt_req_if import skvt_pkg::*; #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_W       = 6
);
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [KEY_WIDTH-1:0]   key;
   logic [VALUE_WIDTH-1:0] value;
   logic [IDX_W-1:0]       position;

   modport source (output valid, kind, key, value, position, input ready);
   modport sink   (input valid, kind, key, value, position, output ready);
endinterface

interface skvt_rsp_if import skvt_pkg::*; #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
);
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [IDX_W-1:0]       entry_index;
   logic [KEY_WIDTH-1:0]   entry_key;
   logic [VALUE_WIDTH-1:0] entry_value;
   logic [STATUS_W-1:0]    status;
   logic [CNT_W-1:0]       count;

   modport source (output valid, found, entry_index, entry_key, entry_value, status, count,
                   input ready);
   modport sink   (input valid, found, entry_index, entry_key, entry_value, status, count,
                   output ready);
endinterface

interface skvt_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/sorted_key_value_table_unit.sv
// top level of the sorted key/value table with mode register and result register
// clear and unused kinds go straight to the response, a probe reads its entry from the ram, an
// append mode search scans the entries in order and sorted mode halves the search range with a
// read and a compare per step; a new key shifts the entries above its place up and then writes
// the entry, an erase shifts them down, one entry moved per cycle; one request at a time
// reset clears the entry count and selects append mode; ram contents are left as they are
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table_unit import skvt_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   skvt_req_if.sink   req_chan,
   skvt_rsp_if.source rsp_chan,
   skvt_csr_if.sink   csr_chan
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH;

   logic                   sorted_mode_ff;
   logic                   core_idle;
   logic                   core_done;
   logic                   done_ready;
   rsp_meta_type           core_meta;
   logic [IDX_W-1:0]       core_index;
   logic [KEY_WIDTH-1:0]   core_key;
   logic [VALUE_WIDTH-1:0] core_value;
   logic [CNT_W-1:0]       core_count;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ENTRY_W-1:0]     mem_wdata;
   logic [IDX_W-1:0]       mem_raddr;
   logic [ENTRY_W-1:0]     mem_rdata;

   logic                   rsp_valid_ff;
   rsp_meta_type           rsp_meta_ff;
   logic [IDX_W-1:0]       rsp_index_ff;
   logic [KEY_WIDTH-1:0]   rsp_key_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sorted_mode_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         sorted_mode_ff <= csr_chan.data;
      end
   end

   assign req_chan.ready = core_idle;
   assign done_ready     = !rsp_valid_ff || rsp_chan.ready;

   skvt_core #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .sorted_mode    (sorted_mode_ff),
      .start          (req_chan.valid && core_idle),
      .start_kind     (req_chan.kind),
      .start_key      (req_chan.key),
      .start_value    (req_chan.value),
      .start_position (req_chan.position),
      .idle           (core_idle),
      .done           (core_done),
      .done_ready     (done_ready),
      .res_meta       (core_meta),
      .res_index      (core_index),
      .res_key        (core_key),
      .res_value      (core_value),
      .res_count      (core_count),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   skvt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done && done_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done && done_ready) begin
         rsp_meta_ff  <= core_meta;
         rsp_index_ff <= core_index;
         rsp_key_ff   <= core_key;
         rsp_value_ff <= core_value;
         rsp_count_ff <= core_count;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_meta_ff.found;
   assign rsp_chan.status      = rsp_meta_ff.status;
   assign rsp_chan.entry_index = rsp_index_ff;
   assign rsp_chan.entry_key   = rsp_key_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.count       = rsp_count_ff;

endmodule

`default_nettype wire

>>> rtl/skvt_ram.sv
// generic single write, single registered read port ram
`timescale 1ns / 1ps
`default_nettype none

module skvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/skvt_core.sv
// search, shift and update sequencer over the entry ram
`timescale 1ns / 1ps
`default_nettype none

module skvt_core import skvt_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   localparam int IDX_W   = $clog2(DEPTH),
   localparam int CNT_W   = $clog2(DEPTH + 1),
   localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   sorted_mode,
   input  wire logic                   start,
   input  wire logic [KIND_W-1:0]      start_kind,
   input  wire logic [KEY_WIDTH-1:0]   start_key,
   input  wire logic [VALUE_WIDTH-1:0] start_value,
   input  wire logic [IDX_W-1:0]       start_position,
   output logic                        idle,
   output logic                        done,
   input  wire logic                   done_ready,
   output rsp_meta_type                res_meta,
   output logic      [IDX_W-1:0]       res_index,
   output logic      [KEY_WIDTH-1:0]   res_key,
   output logic      [VALUE_WIDTH-1:0] res_value,
   output logic      [CNT_W-1:0]       res_count,
   output logic                        mem_we,
   output logic      [IDX_W-1:0]       mem_waddr,
   output logic      [ENTRY_W-1:0]     mem_wdata,
   output logic      [IDX_W-1:0]       mem_raddr,
   input  wire logic [ENTRY_W-1:0]     mem_rdata
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   state_type              state_ff, state_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       lo_ff, lo_in;
   logic [CNT_W-1:0]       hi_ff, hi_in;
   logic [IDX_W-1:0]       mid_ff, mid_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic                   hit_ff, hit_in;
   logic [CNT_W-1:0]       loc_ff, loc_in;
   logic [VALUE_WIDTH-1:0] held_ff, held_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       nxt_ff, nxt_in;
   logic [IDX_W-1:0]       wtgt_ff, wtgt_in;
   rsp_meta_type           meta_ff, meta_in;
   logic [IDX_W-1:0]       rindex_ff, rindex_in;
   logic [KEY_WIDTH-1:0]   rkey_ff, rkey_in;
   logic [VALUE_WIDTH-1:0] rvalue_ff, rvalue_in;

   logic [KEY_WIDTH-1:0]   rd_key;
   logic [VALUE_WIDTH-1:0] rd_val;
   logic [CNT_W-1:0]       span;
   logic [CNT_W-1:0]       mid_calc;
   logic                   lin_hit;
   logic                   lin_end;
   logic                   probe_ok;
   logic                   erase_op;
   logic                   up_more;
   logic                   down_more;

   assign rd_key    = mem_rdata[ENTRY_W-1 -: KEY_WIDTH];
   assign rd_val    = mem_rdata[VALUE_WIDTH-1:0];
   assign span      = hi_ff - lo_ff - ONE_CNT;
   assign mid_calc  = lo_ff + (span >> 1);
   assign lin_hit   = pend_ff && (rd_key == key_ff);
   assign lin_end   = (scan_ff == count_ff);
   assign probe_ok  = (CNT_W'(start_position) < count_ff);
   assign erase_op  = (kind_ff == KIND_ERASE);
   assign up_more   = (nxt_ff > loc_ff);
   assign down_more = ((nxt_ff + ONE_CNT) < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (start_kind)
                  KIND_LOOKUP, KIND_SET, KIND_INSERT, KIND_ERASE: begin
                     state_in = sorted_mode ? ST_BREAD : ST_LSCAN;
                  end
                  KIND_PROBE: begin
                     state_in = probe_ok ? ST_PROBE_RD : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_LSCAN: begin
            if (lin_hit || lin_end) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_BREAD: begin
            state_in = (lo_ff < hi_ff) ? ST_BCMP : ST_DISPATCH;
         end
         ST_BCMP: begin
            state_in = (rd_key == key_ff) ? ST_DISPATCH : ST_BREAD;
         end
         ST_DISPATCH: begin
            priority if (kind_ff == KIND_ERASE) begin
               state_in = hit_ff ? ST_SHIFT : ST_RESP;
            end else if ((kind_ff == KIND_SET || kind_ff == KIND_INSERT) && !hit_ff &&
                         count_ff < DEPTH_CNT) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            if (!pend_ff && !(erase_op ? down_more : up_more)) begin
               state_in = erase_op ? ST_RESP : ST_PLACE;
            end
         end
         ST_PLACE:      state_in = ST_RESP;
         ST_PROBE_RD:   state_in = ST_PROBE_WAIT;
         ST_PROBE_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      kind_in   = kind_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      pos_in    = pos_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      hit_in    = hit_ff;
      loc_in    = loc_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      nxt_in    = nxt_ff;
      wtgt_in   = wtgt_ff;
      meta_in   = meta_ff;
      rindex_in = rindex_ff;
      rkey_in   = rkey_ff;
      rvalue_in = rvalue_ff;
      mem_we    = 1'b0;
      mem_waddr = wtgt_ff;
      mem_wdata = mem_rdata;
      mem_raddr = '0;
      idle      = 1'b0;
      done      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               kind_in   = start_kind;
               key_in    = start_key;
               val_in    = start_value;
               pos_in    = start_position;
               lo_in     = '0;
               hi_in     = count_ff;
               scan_in   = '0;
               pend_in   = 1'b0;
               meta_in   = '{found: 1'b0, status: STATUS_OK};
               rindex_in = '0;
               rkey_in   = '0;
               rvalue_in = '0;
               if (start_kind == KIND_PROBE && !probe_ok) begin
                  meta_in.status = STATUS_RANGE;
               end
               if (start_kind == KIND_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_LSCAN: begin
            priority if (lin_hit) begin
               hit_in  = 1'b1;
               loc_in  = scan_ff - ONE_CNT;
               held_in = rd_val;
            end else if (lin_end) begin
               hit_in = 1'b0;
               loc_in = count_ff;
            end else begin
               mem_raddr = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + ONE_CNT;
               pend_in   = 1'b1;
            end
         end
         ST_BREAD: begin
            if (lo_ff < hi_ff) begin
               mem_raddr = mid_calc[IDX_W-1:0];
               mid_in    = mid_calc[IDX_W-1:0];
            end else begin
               hit_in = 1'b0;
               loc_in = lo_ff;
            end
         end
         ST_BCMP: begin
            priority if (rd_key > key_ff) begin
               hi_in = CNT_W'(mid_ff);
            end else if (rd_key < key_ff) begin
               lo_in = CNT_W'(mid_ff) + ONE_CNT;
            end else begin
               hit_in  = 1'b1;
               loc_in  = CNT_W'(mid_ff);
               held_in = rd_val;
            end
         end
         ST_DISPATCH: begin
            pend_in = 1'b0;
            nxt_in  = hit_ff ? loc_ff : count_ff;
            if (hit_ff) begin
               meta_in   = '{found: 1'b1, status: STATUS_OK};
               rindex_in = loc_ff[IDX_W-1:0];
               rkey_in   = key_ff;
               rvalue_in = held_ff;
               if (kind_ff == KIND_SET) begin
                  mem_we    = 1'b1;
                  mem_waddr = loc_ff[IDX_W-1:0];
                  mem_wdata = {key_ff, val_ff};
               end
            end else if (kind_ff == KIND_LOOKUP || kind_ff == KIND_ERASE) begin
               meta_in.status = STATUS_NOT_FOUND;
            end else if (count_ff >= DEPTH_CNT) begin
               meta_in.status = STATUS_FULL;
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wtgt_ff;
               mem_wdata = mem_rdata;
            end
            if (erase_op) begin
               if (down_more) begin
                  mem_raddr = IDX_W'(nxt_ff + ONE_CNT);
                  wtgt_in   = nxt_ff[IDX_W-1:0];
                  nxt_in    = nxt_ff + ONE_CNT;
                  pend_in   = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     count_in = count_ff - ONE_CNT;
                  end
               end
            end else begin
               if (up_more) begin
                  mem_raddr = IDX_W'(nxt_ff - ONE_CNT);
                  wtgt_in   = nxt_ff[IDX_W-1:0];
                  nxt_in    = nxt_ff - ONE_CNT;
                  pend_in   = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = loc_ff[IDX_W-1:0];
            mem_wdata = {key_ff, val_ff};
            count_in  = count_ff + ONE_CNT;
            meta_in   = '{found: 1'b0, status: STATUS_OK};
            rindex_in = loc_ff[IDX_W-1:0];
            rkey_in   = key_ff;
            rvalue_in = (kind_ff == KIND_SET) ? '0 : val_ff;
         end
         ST_PROBE_RD: begin
            mem_raddr = pos_ff;
         end
         ST_PROBE_WAIT: begin
            meta_in   = '{found: 1'b1, status: STATUS_OK};
            rindex_in = pos_ff;
            rkey_in   = rd_key;
            rvalue_in = rd_val;
         end
         ST_RESP: begin
            done = 1'b1;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      scan_ff   <= scan_in;
      hit_ff    <= hit_in;
      loc_ff    <= loc_in;
      held_ff   <= held_in;
      nxt_ff    <= nxt_in;
      wtgt_ff   <= wtgt_in;
      meta_ff   <= meta_in;
      rindex_ff <= rindex_in;
      rkey_ff   <= rkey_in;
      rvalue_ff <= rvalue_in;
   end

   assign res_meta  = meta_ff;
   assign res_index = rindex_ff;
   assign res_key   = rkey_ff;
   assign res_value = rvalue_ff;
   assign res_count = count_ff;

endmodule

`default_nettype wire
